>>> hw/rtl/mbrt_pkg.sv
// shared types and constants for the missing block range tracker
`default_nettype none

package mbrt_pkg;

    localparam int MAX_BLOCKS = 4096;
    localparam int IDX_W      = 12;
    localparam int CNT_W      = 13;
    localparam int WORD_W     = 64;
    localparam int OFF_W      = 6;
    localparam int WADDR_W    = IDX_W - OFF_W;
    localparam int NWORDS     = MAX_BLOCKS / WORD_W;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 40;

    localparam logic [CNT_W-1:0] BLOCK_COUNT_RESET = CNT_W'(4096);

    localparam logic MODE_ARRIVE = 1'b0;
    localparam logic MODE_SCAN   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_FILL,
        S_ARR_RD,
        S_ARR_UPD,
        S_EMIT_ONE,
        S_SRCH_RD,
        S_SRCH,
        S_RUN_RD,
        S_RUN,
        S_TAIL_RD,
        S_TAIL,
        S_FINISH
    } state_t;

    typedef enum logic [1:0] {
        EMIT_NONE,
        EMIT_PLAIN,
        EMIT_HELD,
        EMIT_LAST
    } emit_t;

    typedef struct packed {
        logic  accept;
        logic  start;
        logic  fill_wr;
        logic  arr_upd;
        logic  scan_init;
        logic  find_zero;
        logic  run_open;
        logic  run_close;
        logic  next_word;
        logic  set_more;
        logic  finish;
        emit_t emit;
    } cmd_t;

    typedef struct packed {
        logic started;
        logic mode;
        logic fill_last;
        logic hit;
        logic last_word;
        logic held_valid;
        logic runs_at_limit;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/mbrt_ctrl.sv
// controller state machine for the missing block range tracker
`default_nettype none

module mbrt_ctrl
    import mbrt_pkg::*;
(
    input  wire   clk,
    input  wire   rst_n,
    input  wire   s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.emit   = EMIT_NONE;
        s_tready   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.mode == MODE_ARRIVE)
                begin
                    if (!stat.started)
                    begin
                        cmd.start  = 1'b1;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        state_next = S_ARR_RD;
                    end
                end
                else if (!stat.started)
                begin
                    state_next = S_EMIT_ONE;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_FILL:
            begin
                cmd.fill_wr = 1'b1;
                if (stat.fill_last)
                begin
                    state_next = S_ARR_RD;
                end
            end
            S_ARR_RD:
            begin
                state_next = S_ARR_UPD;
            end
            S_ARR_UPD:
            begin
                cmd.arr_upd = 1'b1;
                state_next  = S_EMIT_ONE;
            end
            S_EMIT_ONE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = EMIT_PLAIN;
                    state_next = S_IDLE;
                end
            end
            S_SRCH_RD:
            begin
                state_next = S_SRCH;
            end
            S_SRCH:
            begin
                if (stat.hit)
                begin
                    cmd.run_open = 1'b1;
                    state_next   = S_RUN;
                end
                else if (stat.last_word)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.next_word = 1'b1;
                    state_next    = S_SRCH_RD;
                end
            end
            S_RUN_RD:
            begin
                cmd.find_zero = 1'b1;
                state_next    = S_RUN;
            end
            S_RUN:
            begin
                cmd.find_zero = 1'b1;
                if (stat.hit || stat.last_word)
                begin
                    // previous range goes out before the new one is held
                    if (!stat.held_valid || stat.out_free)
                    begin
                        cmd.run_close = 1'b1;
                        if (stat.held_valid)
                        begin
                            cmd.emit = EMIT_HELD;
                        end
                        if (!stat.hit)
                        begin
                            state_next = S_FINISH;
                        end
                        else if (stat.runs_at_limit)
                        begin
                            state_next = S_TAIL;
                        end
                        else
                        begin
                            state_next = S_SRCH;
                        end
                    end
                end
                else
                begin
                    cmd.next_word = 1'b1;
                    state_next    = S_RUN_RD;
                end
            end
            S_TAIL_RD:
            begin
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                if (stat.hit)
                begin
                    cmd.set_more = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (stat.last_word)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    cmd.next_word = 1'b1;
                    state_next    = S_TAIL_RD;
                end
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = EMIT_LAST;
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> hw/rtl/mbrt_dp.sv
// datapath: bitmap memory, counters, scan position and output register
`default_nettype none

module mbrt_dp
    import mbrt_pkg::*;
#(
    parameter int MAX_RANGES = 12
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    input  cmd_t                   cmd,
    output stat_t                  stat,
    input  wire                    in_mode,
    input  wire  [IDX_W-1:0]       in_index,
    input  wire                    cfg_wr_en,
    input  wire  [CNT_W-1:0]       cfg_wr_data,
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,
    output logic                   m_tuser,
    output logic                   m_tlast
);

    localparam int RUN_W = $clog2(MAX_RANGES + 1);

    logic [WORD_W-1:0] mem [NWORDS];

    logic               mode_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic               err_reg;
    logic [CNT_W-1:0]   bc_reg;
    logic [CNT_W-1:0]   active_reg;
    logic               started_reg;
    logic [CNT_W-1:0]   remain_reg;
    logic [IDX_W-1:0]   cursor_reg;
    logic [WADDR_W-1:0] fill_ctr_reg;
    logic [WADDR_W-1:0] pos_word_reg;
    logic [OFF_W-1:0]   pos_off_reg;
    logic [IDX_W-1:0]   run_first_reg;
    logic [IDX_W-1:0]   held_first_reg;
    logic [IDX_W-1:0]   held_last_reg;
    logic               held_valid_reg;
    logic [RUN_W-1:0]   nruns_reg;
    logic               more_reg;
    logic [IDX_W-1:0]   saved_reg;
    logic [WORD_W-1:0]  rdata_reg;

    logic               out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic               out_user_reg;
    logic               out_last_reg;

    logic [CNT_W-1:0]   clamp_count;
    logic [WORD_W-1:0]  fill_mask;
    logic [WADDR_W-1:0] rd_addr;
    logic               mem_we;
    logic [WADDR_W-1:0] mem_waddr;
    logic [WORD_W-1:0]  mem_wdata;
    logic               arr_err;
    logic               arr_bit;
    logic [WORD_W-1:0]  scan_vec;
    logic               hit;
    logic [OFF_W-1:0]   hpos;
    logic [CNT_W-1:0]   edge_pos;
    logic               out_free;
    logic               rv;

    // count taken at start, clamped to 1..MAX_BLOCKS
    always_comb
    begin
        if (bc_reg == '0)
        begin
            clamp_count = CNT_W'(1);
        end
        else if (bc_reg > CNT_W'(MAX_BLOCKS))
        begin
            clamp_count = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            clamp_count = bc_reg;
        end
    end

    // start-up fill word: ones below the active count, zeros above
    always_comb
    begin
        if ({1'b0, fill_ctr_reg} < active_reg[CNT_W-1:OFF_W])
        begin
            fill_mask = '1;
        end
        else if ({1'b0, fill_ctr_reg} == active_reg[CNT_W-1:OFF_W])
        begin
            fill_mask = ~({WORD_W{1'b1}} << active_reg[OFF_W-1:0]);
        end
        else
        begin
            fill_mask = '0;
        end
    end

    assign arr_err = {1'b0, idx_reg} >= active_reg;
    assign arr_bit = rdata_reg[idx_reg[OFF_W-1:0]];
    assign rd_addr = (mode_reg == MODE_ARRIVE) ? idx_reg[IDX_W-1:OFF_W] : pos_word_reg;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg[IDX_W-1:OFF_W];
        mem_wdata = rdata_reg & ~({{(WORD_W-1){1'b0}}, 1'b1} << idx_reg[OFF_W-1:0]);
        if (cmd.fill_wr)
        begin
            mem_we    = 1'b1;
            mem_waddr = fill_ctr_reg;
            mem_wdata = fill_mask;
        end
        else if (cmd.arr_upd && !arr_err && arr_bit)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    // lowest set bit (clear bit when looking for a zero) at or above the current offset
    assign scan_vec = (cmd.find_zero ? ~rdata_reg : rdata_reg)
                      & ({WORD_W{1'b1}} << pos_off_reg);

    always_comb
    begin
        hit  = 1'b0;
        hpos = '0;
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (scan_vec[i])
            begin
                hit  = 1'b1;
                hpos = OFF_W'(i);
            end
        end
    end

    // a run still open at the top of the map ends at the last block
    assign edge_pos = hit ? {1'b0, pos_word_reg, hpos} : CNT_W'(MAX_BLOCKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bc_reg         <= BLOCK_COUNT_RESET;
            active_reg     <= '0;
            started_reg    <= 1'b0;
            remain_reg     <= '0;
            cursor_reg     <= '0;
            fill_ctr_reg   <= '0;
            held_valid_reg <= 1'b0;
            nruns_reg      <= '0;
            more_reg       <= 1'b0;
            mode_reg       <= MODE_ARRIVE;
            err_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                bc_reg <= cfg_wr_data;
            end
            if (cmd.accept)
            begin
                mode_reg <= in_mode;
                err_reg  <= 1'b0;
            end
            if (cmd.start)
            begin
                active_reg   <= clamp_count;
                remain_reg   <= clamp_count;
                started_reg  <= 1'b1;
                fill_ctr_reg <= '0;
            end
            if (cmd.fill_wr)
            begin
                fill_ctr_reg <= fill_ctr_reg + 1'b1;
            end
            if (cmd.arr_upd)
            begin
                err_reg <= arr_err;
                if (!arr_err && arr_bit)
                begin
                    remain_reg <= remain_reg - 1'b1;
                end
            end
            if (cmd.scan_init)
            begin
                held_valid_reg <= 1'b0;
                nruns_reg      <= '0;
                more_reg       <= 1'b0;
            end
            if (cmd.run_close)
            begin
                held_valid_reg <= 1'b1;
                nruns_reg      <= nruns_reg + 1'b1;
            end
            if (cmd.set_more)
            begin
                more_reg <= 1'b1;
            end
            if (cmd.finish)
            begin
                cursor_reg <= more_reg ? saved_reg : '0;
            end
        end
    end

    // scan position and range payload
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg <= in_index;
        end
        if (cmd.scan_init)
        begin
            pos_word_reg <= cursor_reg[IDX_W-1:OFF_W];
            pos_off_reg  <= cursor_reg[OFF_W-1:0];
        end
        else if (cmd.next_word)
        begin
            pos_word_reg <= pos_word_reg + 1'b1;
            pos_off_reg  <= '0;
        end
        else if (cmd.run_open || cmd.run_close)
        begin
            pos_off_reg <= hpos;
        end
        if (cmd.run_open)
        begin
            run_first_reg <= {pos_word_reg, hpos};
        end
        if (cmd.run_close)
        begin
            held_first_reg <= run_first_reg;
            held_last_reg  <= IDX_W'(edge_pos - 1'b1);
            saved_reg      <= edge_pos[IDX_W-1:0];
        end
    end

    // output register
    assign out_free = !out_valid_reg || m_tready;
    assign rv = (cmd.emit == EMIT_HELD) || ((cmd.emit == EMIT_LAST) && held_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit != EMIT_NONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit != EMIT_NONE)
        begin
            out_user_reg <= rv;
            out_last_reg <= (cmd.emit != EMIT_HELD);
            out_data_reg <= {
                (cmd.emit == EMIT_PLAIN) ? err_reg : 1'b0,
                remain_reg,
                started_reg && (remain_reg == '0),
                (cmd.emit == EMIT_LAST) && held_valid_reg && more_reg,
                rv ? held_last_reg : {IDX_W{1'b0}},
                rv ? held_first_reg : {IDX_W{1'b0}}
            };
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    assign stat.started       = started_reg;
    assign stat.mode          = mode_reg;
    assign stat.fill_last     = (fill_ctr_reg == '1);
    assign stat.hit           = hit;
    assign stat.last_word     = (pos_word_reg == '1);
    assign stat.held_valid    = held_valid_reg;
    assign stat.runs_at_limit = (nruns_reg == RUN_W'(MAX_RANGES - 1));
    assign stat.out_free      = out_free;

endmodule

`default_nettype wire

>>> hw/rtl/missing_block_range_tracker_top.sv
// top level of the missing block range tracker
`default_nettype none

// channel   direction  handshake            payload
// s_*       in         s_tvalid / s_tready  s_tuser mode, s_tdata block_index
// m_*       out        m_tvalid / m_tready  m_tuser range_valid, m_tlast last,
//                                           m_tdata range and status fields
// cfg_*     in         cfg_wr_en            cfg_wr_data block_count
//
// an arrival passes the dispatch, read, update and emit states and then the output
// register after its input transfer, and the controller is back in idle to take the
// next input transfer as its result is presented; the first arrival after reset
// first writes all 64 bitmap words for the start-up fill
// a scan reads the 64-bit bitmap words it visits one at a time through the single
// memory read port; a new range is held only once the previous one can go out
// the bitmap is not cleared by reset; the first arrival fills it
// one item is in work at a time; a result waiting in the output register
// does not block the next input transfer, only the next result

module missing_block_range_tracker_top
    import mbrt_pkg::*;
#(
    parameter int MAX_RANGES = 12
)
(
    input  wire                    clk,
    input  wire                    rst_n,
    // slave side
    input  wire                    s_tvalid,
    output logic                   s_tready,
    input  wire  [IN_DATA_W-1:0]   s_tdata,   // [11:0] block_index
    input  wire                    s_tuser,   // mode
    // master side
    output logic                   m_tvalid,
    input  wire                    m_tready,
    output logic [OUT_DATA_W-1:0]  m_tdata,   // [11:0] start_block, [23:12] end_block,
                                              // [24] more_pending, [25] complete,
                                              // [38:26] missing_count, [39] index_error
    output logic                   m_tuser,   // range_valid
    output logic                   m_tlast,   // last result of this item
    // configuration
    input  wire                    cfg_wr_en,
    input  wire  [CNT_W-1:0]       cfg_wr_data  // block_count
);

    cmd_t  cmd;
    stat_t stat;

    // controller: sequences fill, arrival update and the bitmap walk
    mbrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: bitmap, counters, range tracking, output register
    mbrt_dp #(
        .MAX_RANGES (MAX_RANGES)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .in_mode     (s_tuser),
        .in_index    (s_tdata[IDX_W-1:0]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

`default_nettype wire
